// ----- design/sae_pkg.sv -----
// ----------------------------------------------------------------------------
// sae_pkg: shared types for the sampled voice envelope unit
// Op codes, stage codes, beat widths and the controller/datapath link.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sae_pkg;

  // beat widths
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  // top of the envelope range
  localparam logic [7:0] ENV_MAX = 8'd255;

  // op carried on the input tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_RELEASE = 2'd2,
    OP_PAN     = 2'd3
  } op_t;

  // voice stage
  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_PEND    = 3'd1,
    ST_ATTACK  = 3'd2,
    ST_DECAY   = 3'd3,
    ST_SUSTAIN = 3'd4,
    ST_ECHO    = 3'd5
  } stage_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // beat taken: apply op, or start rate multiply on tick
    logic step;       // advance the envelope stage
    logic lvl_left;   // multiply left volume by envelope
    logic lvl_right;  // store left level, multiply right volume
    logic lvl_write;  // store right level
    logic out_load;   // capture result into output register
  } sae_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_tick;     // op on the input beat is a tick
    logic need_levels; // stage step ends with a level update
    logic out_busy;    // output register holds a beat not yet taken
  } sae_status_t;

endpackage

`default_nettype wire

// ----- design/sae_ctrl.sv -----
// ----------------------------------------------------------------------------
// sae_ctrl: sequencer for the envelope unit
// Walks each accepted beat to output; a tick goes first through stage step and, if needed, level multiplies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sae_ctrl
  import sae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sae_status_t status,
  output sae_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_LVL_L,
    S_LVL_R,
    S_LVL_W,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // ready only between items
  assign in_ready = (state == S_IDLE);

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.is_tick ? S_STEP : S_OUT;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.need_levels ? S_LVL_L : S_OUT;
      end
      S_LVL_L: begin
        cmd.lvl_left = 1'b1;
        state_next   = S_LVL_R;
      end
      S_LVL_R: begin
        cmd.lvl_right = 1'b1;
        state_next    = S_LVL_W;
      end
      S_LVL_W: begin
        cmd.lvl_write = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("beat accepted while an item is in flight");

  // non-tick ops go straight to the output step
  a_op_to_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !status.is_tick) |=> (state == S_OUT))
    else $error("non-tick op did not go to output");

  // right level store follows the right multiply
  a_lvl_order: assert property (@(posedge clk) disable iff (rst)
    cmd.lvl_write |-> $past(cmd.lvl_right))
    else $error("right level stored without its multiply");

endmodule

`default_nettype wire

// ----- design/sae_dp.sv -----
// ----------------------------------------------------------------------------
// sae_dp: envelope datapath
// Voice state, note parameters, shared 8x8 multiplier and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sae_dp
  import sae_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic [IN_USER_W-1:0]  in_user,
  input  wire sae_cmd_t              cmd,
  output sae_status_t                status,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [OUT_DATA_W-1:0]      out_data
);

  // voice state
  stage_t     stage;
  logic       stop_mark;
  logic [7:0] envelope;
  logic [7:0] echo_left;
  logic [7:0] left_level;
  logic [7:0] right_level;

  // latched note parameters and pan
  logic [7:0] attack_rate;
  logic [7:0] decay_rate;
  logic [7:0] sustain_level;
  logic [7:0] release_rate;
  logic [7:0] echo_level;
  logic       wave_present;
  logic [7:0] left_volume;
  logic [7:0] right_volume;

  // shared multiplier
  logic [7:0]  mul_a;
  logic [7:0]  mul_b;
  logic [15:0] product;
  logic [7:0]  mul_res;

  // tick step results
  stage_t     tk_stage;
  logic       tk_stop;
  logic [7:0] tk_env;
  logic [7:0] tk_echo;
  logic       tk_levels;
  logic [7:0] env_base;
  logic [8:0] att_sum;

  op_t op;

  assign op      = op_t'(in_user);
  assign mul_res = product[15:8];

  // envelope base: a pending start begins from zero
  assign env_base = (stage == ST_PEND) ? 8'd0 : envelope;
  assign att_sum  = {1'b0, env_base} + {1'b0, attack_rate};

  // multiplier operand select
  always_comb begin
    mul_a = env_base;
    mul_b = stop_mark ? release_rate : decay_rate;
    if (cmd.lvl_left) begin
      mul_a = left_volume;
      mul_b = envelope;
    end else if (cmd.lvl_right) begin
      mul_a = right_volume;
      mul_b = envelope;
    end
  end

  // stage step for one tick, rate product already in place
  always_comb begin
    tk_stage  = stage;
    tk_stop   = stop_mark;
    tk_env    = envelope;
    tk_echo   = echo_left;
    tk_levels = 1'b0;
    if (stage == ST_OFF) begin
      tk_levels = 1'b0;
    end else if (stage == ST_ECHO) begin
      // count down the echo, off when it runs out
      if (echo_left == 8'd0) begin
        tk_stage = ST_OFF;
        tk_stop  = 1'b0;
      end else begin
        tk_echo = echo_left - 8'd1;
        if (echo_left == 8'd1) begin
          tk_stage = ST_OFF;
          tk_stop  = 1'b0;
        end
      end
    end else if (stage == ST_PEND && (stop_mark || !wave_present)) begin
      tk_stage = ST_OFF;
      tk_stop  = 1'b0;
    end else begin
      if (stage == ST_PEND) begin
        tk_stage = ST_ATTACK;
      end
      tk_env    = env_base;
      tk_levels = 1'b1;
      if (stop_mark) begin
        // release toward the echo level
        if (mul_res <= echo_level) begin
          tk_levels = 1'b0;
          tk_env    = echo_level;
          tk_stop   = 1'b0;
          if (echo_level != 8'd0 && echo_left != 8'd0) begin
            tk_stage = ST_ECHO;
          end else begin
            tk_stage = ST_OFF;
          end
        end else begin
          tk_env = mul_res;
        end
      end else if (stage == ST_ATTACK || stage == ST_PEND) begin
        // additive attack, saturating into decay
        if (att_sum >= {1'b0, ENV_MAX}) begin
          tk_env   = ENV_MAX;
          tk_stage = ST_DECAY;
        end else begin
          tk_env = att_sum[7:0];
        end
      end else if (stage == ST_DECAY) begin
        // multiplicative decay down to sustain
        if (mul_res <= sustain_level) begin
          if (sustain_level == 8'd0) begin
            tk_levels = 1'b0;
            tk_env    = echo_level;
            tk_stop   = 1'b0;
            if (echo_level != 8'd0 && echo_left != 8'd0) begin
              tk_stage = ST_ECHO;
            end else begin
              tk_stage = ST_OFF;
            end
          end else begin
            tk_env   = sustain_level;
            tk_stage = ST_SUSTAIN;
          end
        end else begin
          tk_env = mul_res;
        end
      end
    end
  end

  // status to controller
  assign status.is_tick     = (op == OP_TICK);
  assign status.need_levels = tk_levels;
  assign status.out_busy    = out_valid && !out_ready;

  // multiplier product register
  always_ff @(posedge clk) begin
    if ((cmd.accept && op == OP_TICK) || cmd.lvl_left || cmd.lvl_right) begin
      product <= mul_a * mul_b;
    end
  end

  // voice state and parameter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ST_OFF;
      stop_mark     <= 1'b0;
      envelope      <= 8'd0;
      echo_left     <= 8'd0;
      left_level    <= 8'd0;
      right_level   <= 8'd0;
      attack_rate   <= 8'd0;
      decay_rate    <= 8'd0;
      sustain_level <= 8'd0;
      release_rate  <= 8'd0;
      echo_level    <= 8'd0;
      wave_present  <= 1'b0;
      left_volume   <= 8'd0;
      right_volume  <= 8'd0;
    end else begin
      if (cmd.accept) begin
        unique case (op)
          OP_TICK: begin
          end
          OP_NOTE_ON: begin
            attack_rate   <= in_data[7:0];
            decay_rate    <= in_data[15:8];
            sustain_level <= in_data[23:16];
            release_rate  <= in_data[31:24];
            echo_level    <= in_data[39:32];
            echo_left     <= in_data[47:40];
            wave_present  <= in_data[48];
            left_volume   <= in_data[56:49];
            right_volume  <= in_data[64:57];
            stop_mark     <= 1'b0;
            stage         <= ST_PEND;
          end
          OP_RELEASE: begin
            if (stage != ST_OFF) begin
              stop_mark <= 1'b1;
            end
          end
          OP_PAN: begin
            left_volume  <= in_data[56:49];
            right_volume <= in_data[64:57];
          end
          default: begin
          end
        endcase
      end
      if (cmd.step) begin
        stage     <= tk_stage;
        stop_mark <= tk_stop;
        envelope  <= tk_env;
        echo_left <= tk_echo;
      end
      if (cmd.lvl_right) begin
        left_level <= mul_res;
      end
      if (cmd.lvl_write) begin
        right_level <= mul_res;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {3'd0, right_level, left_level, envelope, stop_mark,
                   stage, (stage != ST_OFF)};
    end
  end

  // echo stage always has ticks left
  a_echo_count: assert property (@(posedge clk) disable iff (rst)
    (stage == ST_ECHO) |-> (echo_left != 8'd0))
    else $error("echo stage with empty count");

  // a waiting beat is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

// ----- design/sample_adsr_envelope_unit.sv -----
// ----------------------------------------------------------------------------
// sample_adsr_envelope_unit: envelope generator for one sampled voice
// Controller and datapath for attack, decay, sustain, release and echo.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: tuser carries the op (tick, note_on, release,
//   set pan), tdata the note fields. Every accepted beat gives exactly one
//   output beat on m_axis_* with the voice state after the op.
//   Sequence: a non-tick op goes from accept straight to the output step;
//   a tick passes the stage step and, when it updates the pan levels, the
//   level multiplies, in turn on the single shared 8x8 multiplier for the
//   rate, left and right products. One item at a time; the next beat is
//   taken the cycle after the output register is loaded.
//   Reset (rst, synchronous): voice off, envelope, levels and note fields
//   cleared, no output beat pending.
//   Stall: the output register holds a beat until m_axis_tready; a new
//   input beat is accepted meanwhile, and its result waits until the
//   register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sample_adsr_envelope_unit
  import sae_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // attack_rate, decay_rate, sustain_level, release_rate, echo_level,
  // echo_ticks, wave_present, left_volume, right_volume, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // active, stage, releasing, envelope_level, left_level, right_level,
  // zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  sae_cmd_t    cmd;
  sae_status_t status;

  // sequencer
  sae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // envelope datapath
  sae_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire
